@@ src/edd_pkg.sv @@
// Shared types, constants and arithmetic helpers of the error diffusion dither.
`default_nettype none

package edd_pkg;

    // Default line store depth.
    localparam int MAX_WIDTH_DEF = 1024;

    // Channel arithmetic.
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 9;
    localparam int RECIP_W    = 26;
    localparam int RECIP_SHIFT = 25;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DITHER_ENABLE = 2'd2;

    typedef struct packed {
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
        logic       frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       line_end;
    } t_pix_out;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_Q1,
        S_Q2,
        S_Q3,
        S_WR2
    } t_state;

    // Stage controls handed from the sequencer to each channel.
    typedef struct packed {
        logic clr;
        logic ld_q1;
        logic ld_q2;
        logic commit;
        logic last;
        logic dither;
        logic use_row;
    } t_chan_ctl;

    // ceil(2^RECIP_SHIFT / (2^bits - 1)) for bits 1..8.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [3:0] bits);
        logic [RECIP_W-1:0] r;
        case (bits)
            4'd1:    r = 26'd33554432;
            4'd2:    r = 26'd11184811;
            4'd3:    r = 26'd4793491;
            4'd4:    r = 26'd2236963;
            4'd5:    r = 26'd1082402;
            4'd6:    r = 26'd532611;
            4'd7:    r = 26'd264209;
            default: r = 26'd131587;
        endcase
        return r;
    endfunction

    // (e * w) / 16 with truncation toward zero.
    function automatic logic signed [ERR_W-1:0] wdiv16(input logic signed [ERR_W-1:0] e,
                                                      input logic [3:0] w);
        logic signed [13:0] p;
        p = 14'(e) * 14'($signed({1'b0, w}));
        if (p < 0) begin
            p = p + 14'sd15;
        end
        return ERR_W'(p >>> 4);
    endfunction

endpackage

`default_nettype wire

@@ src/error_diffusion_dither.sv @@
// Top level of the error diffusion dither with its line store and sequencer.
// Path: input and line store read registers, Q1 and Q2 registers, result register;
// a stalled output holds the item in Q3. Throughput: one item at a time; the line
// store read, the three quantizer stages, an extra store write on a line's last
// pixel and the right-neighbor error set it. Reset: synchronous, active low;
// the line store is then swept to zero, taking no item (configuration writes are).
`default_nettype none

module error_diffusion_dither #(
    parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [edd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  edd_pkg::t_pix_in                  i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output edd_pkg::t_pix_out                 o_out
);
    import edd_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    // Width values are compared in enough bits for both the register and the depth.
    localparam int CW = (AW + 1 > CFG_DATA_W) ? AW + 1 : CFG_DATA_W;
    localparam int MW = 3 * ERR_W;

    // Configuration registers.
    logic [3:0]            r_color_bits;
    logic [CFG_DATA_W-1:0] r_line_width;
    logic                  r_dither;

    // Sequencer and row position.
    t_state                r_state;
    t_state                n_state;
    logic [AW-1:0]         r_clr_addr;
    logic [AW-1:0]         r_col;
    logic [AW-1:0]         r_cur_col;
    logic                  r_last;
    logic                  r_first_row;
    t_pix_in               r_in;
    logic [MW-1:0]         r_wr2_data;

    // Output register.
    t_pix_out              r_out;
    logic                  r_out_valid;

    // Line store: one entry per column holding three signed channel errors.
    logic [MW-1:0]         mem [MAX_WIDTH];
    logic [MW-1:0]         r_rd_data;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [MW-1:0]         mem_wdata;
    logic                  mem_re;

    logic                  in_accept;
    logic                  out_free;
    logic [CW-1:0]         lw_ext;
    logic [AW-1:0]         w_m1;
    logic [AW-1:0]         col_in;
    logic [AW-1:0]         col_now;
    logic [3:0]            bits_eff;
    logic [PIX_W-1:0]      levels;
    logic [RECIP_W-1:0]    recip;
    t_chan_ctl             ctl;

    logic [2:0][PIX_W-1:0] quant;
    logic [2:0][ERR_W-1:0] left_err;
    logic [2:0][ERR_W-1:0] col_err;
    logic [2:0][PIX_W-1:0] pix;

    assign in_accept = i_in_valid && !o_in_stall;
    // The result register can take a new item when empty or being emptied.
    assign out_free  = !r_out_valid || !i_out_stall;

    // Effective line width minus one, clamped to 2..MAX_WIDTH.
    always_comb begin
        lw_ext = CW'(r_line_width);
        if (lw_ext < CW'(2)) begin
            w_m1 = AW'(1);
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            w_m1 = AW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = AW'(lw_ext - CW'(1));
        end
        // A frame start restarts the row; a count past a shrunk width ends the line.
        col_in  = i_in.frame_start ? '0 : r_col;
        col_now = (col_in > w_m1) ? w_m1 : col_in;
    end

    // Palette size and the matching reciprocal for the output rescale.
    always_comb begin
        if (r_color_bits == 4'd0) begin
            bits_eff = 4'd1;
        end else if (r_color_bits > 4'd8) begin
            bits_eff = 4'd8;
        end else begin
            bits_eff = r_color_bits;
        end
        levels = PIX_W'((9'd1 << bits_eff) - 9'd1);
        recip  = recip_of(bits_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_bits <= 4'd2;
            r_line_width <= CFG_DATA_W'(640);
            r_dither     <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLOR_BITS:    r_color_bits <= i_cfg_data[3:0];
                CFG_LINE_WIDTH:    r_line_width <= i_cfg_data;
                CFG_DITHER_ENABLE: r_dither     <= i_cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_Q1;
                end
            end
            S_Q1: n_state = S_Q2;
            S_Q2: n_state = S_Q3;
            S_Q3: begin
                if (out_free) begin
                    n_state = r_last ? S_WR2 : S_IDLE;
                end
            end
            S_WR2:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs: handshake, line store port and channel stage controls.
    always_comb begin
        o_in_stall  = 1'b1;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_cur_col;
        mem_wdata   = r_wr2_data;
        ctl         = '0;
        ctl.last    = r_last;
        ctl.dither  = r_dither;
        ctl.use_row = !r_first_row;
        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                mem_re     = i_in_valid;
                ctl.clr    = i_in_valid && i_in.frame_start;
            end
            S_Q1: ctl.ld_q1 = 1'b1;
            S_Q2: ctl.ld_q2 = 1'b1;
            S_Q3: begin
                // Finish the next-row entry of the column to the left.
                ctl.commit = out_free;
                mem_we     = out_free && (r_cur_col != '0);
                mem_waddr  = r_cur_col - AW'(1);
                mem_wdata  = {left_err[2], left_err[1], left_err[0]};
            end
            S_WR2: begin
                // Last pixel: its own column gets the partial sum as well.
                mem_we    = 1'b1;
                mem_waddr = r_cur_col;
                mem_wdata = r_wr2_data;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_first_row <= 1'b1;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (in_accept && i_in.frame_start) begin
                r_first_row <= 1'b1;
            end
            if (ctl.commit) begin
                if (r_last) begin
                    r_col       <= '0;
                    r_first_row <= 1'b0;
                end else begin
                    r_col <= r_cur_col + AW'(1);
                end
            end
        end
    end

    // Item payload held for its whole pass through the stages.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in      <= i_in;
            r_cur_col <= col_now;
            r_last    <= (col_now == w_m1);
        end
        if (ctl.commit) begin
            r_wr2_data <= {col_err[2], col_err[1], col_err[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[col_now];
        end
    end

    assign pix[0] = r_in.in_blue;
    assign pix[1] = r_in.in_green;
    assign pix[2] = r_in.in_red;

    for (genvar g = 0; g < 3; g++) begin : g_chan
        edd_chan u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_pixel    (pix[g]),
            .i_row_err  (r_rd_data[g*ERR_W +: ERR_W]),
            .i_levels   (levels),
            .i_recip    (recip),
            .o_quant    (quant[g]),
            .o_left_err (left_err[g]),
            .o_col_err  (col_err[g])
        );
    end

    // Result register decouples the output stall from the channel stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.commit) begin
            r_out.out_blue  <= quant[0];
            r_out.out_green <= quant[1];
            r_out.out_red   <= quant[2];
            r_out.line_end  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ src/edd_chan.sv @@
// One color channel: error add and clamp, quantizer and error split.
`default_nettype none

module edd_chan (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  edd_pkg::t_chan_ctl                   i_ctl,
    input  logic [edd_pkg::PIX_W-1:0]            i_pixel,
    input  logic [edd_pkg::ERR_W-1:0]            i_row_err,
    input  logic [edd_pkg::PIX_W-1:0]            i_levels,
    input  logic [edd_pkg::RECIP_W-1:0]          i_recip,
    output logic [edd_pkg::PIX_W-1:0]            o_quant,
    output logic [edd_pkg::ERR_W-1:0]            o_left_err,
    output logic [edd_pkg::ERR_W-1:0]            o_col_err
);
    import edd_pkg::*;

    logic signed [ERR_W-1:0] r_right;
    logic signed [ERR_W-1:0] r_diag;
    logic signed [ERR_W-1:0] r_corner;
    logic [PIX_W-1:0]        r_v;
    logic [15:0]             r_vl;
    logic [41:0]             r_prod;

    logic signed [10:0]      pend;
    logic signed [10:0]      sum;
    logic [PIX_W-1:0]        clamped;
    logic [PIX_W-1:0]        v_sel;
    logic [15:0]             lvl_num;
    logic [16:0]             lvl_tmp;
    logic [PIX_W-1:0]        level;
    logic [15:0]             scaled;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] w7;
    logic signed [ERR_W-1:0] w5;
    logic signed [ERR_W-1:0] w3;
    logic signed [ERR_W-1:0] w1;

    // First stage: add pending error and clamp once.
    always_comb begin
        pend = (i_ctl.use_row ? 11'($signed(i_row_err)) : 11'sd0) + 11'(r_right);
        sum  = $signed({3'b000, i_pixel}) + pend;
        if (sum < 0) begin
            clamped = '0;
        end else if (sum > 11'sd255) begin
            clamped = 8'd255;
        end else begin
            clamped = sum[7:0];
        end
        v_sel = i_ctl.dither ? clamped : i_pixel;
    end

    // Second stage: level = (v*L + 127) / 255, then level*255 times 1/L.
    always_comb begin
        lvl_num = r_vl + 16'd127;
        lvl_tmp = {1'b0, lvl_num} + 17'(lvl_num >> 8) + 17'd1;
        level   = lvl_tmp[15:8];
        scaled  = {level, 8'h00} - {8'h00, level};
    end

    // Third stage: error and its four weighted shares.
    always_comb begin
        o_quant = r_prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
        err = i_ctl.dither ? ($signed({1'b0, r_v}) - $signed({1'b0, o_quant})) : '0;
        w7  = wdiv16(err, 4'd7);
        w5  = wdiv16(err, 4'd5);
        w3  = wdiv16(err, 4'd3);
        w1  = wdiv16(err, 4'd1);
        o_left_err = r_diag + w3;
        o_col_err  = r_corner + w5;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_q1) begin
            r_v  <= v_sel;
            r_vl <= 16'(v_sel) * 16'(i_levels);
        end
        if (i_ctl.ld_q2) begin
            r_prod <= 42'(scaled) * 42'(i_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_right  <= '0;
            r_diag   <= '0;
            r_corner <= '0;
        end else if (i_ctl.commit) begin
            if (i_ctl.last) begin
                r_right  <= '0;
                r_diag   <= '0;
                r_corner <= '0;
            end else begin
                r_right  <= w7;
                r_diag   <= o_col_err;
                r_corner <= w1;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/edd_checker.sv @@
// Port-level checks of the error diffusion dither and their binding.
`default_nettype none

module edd_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input edd_pkg::t_pix_out o_out
);
    import edd_pkg::*;

    // The line store sweep follows reset, so no item is taken right after it.
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken right after reset");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // One item at a time: an accepted item closes the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed or dropped");

endmodule

bind error_diffusion_dither edd_checker u_edd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

@@ verif/error_diffusion_dither_tb.sv @@
// Self-checking testbench for the error diffusion dither: directed table, then random phases.
`timescale 1ns / 1ps

module error_diffusion_dither_tb;
    import edd_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;

    // Kind of a directed table row: a pixel item, or a register write done while idle.
    typedef enum logic {
        ROW_PIX,
        ROW_REG
    } t_row_kind;

    // One row of the directed table. Where known is set, res is the hand-typed result
    // and is used instead of the predicted one.
    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        t_pix_in                px;
        logic                   known;
        t_pix_out               res;
    } t_dir_row;

    // The directed part walks the special cases in order: extremes after reset, a width
    // below two that cuts the current line short, frame starts, color depth below one and
    // above eight, dithering off (plain color reduction), a width above the line store,
    // and a width shrunk in the middle of a line.
    localparam int N_DIR = 34;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h00, 8'h00, 8'h00, 1'b1},
          1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'hFF, 8'hFF, 8'hFF, 1'b0},
          1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h00, 8'hFF, 8'h80, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_LINE_WIDTH, 11'd0, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h80, 8'h40, 8'hC0, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h55, 8'hAA, 8'h01, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h10, 8'hF0, 8'h7F, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h80, 8'h80, 8'h80, 1'b1}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h40, 8'h20, 8'hE0, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'hC8, 8'h37, 8'h91, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_COLOR_BITS, 11'd0, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h7F, 8'h80, 8'hC8, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h01, 8'hFE, 8'h80, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_COLOR_BITS, 11'd15, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h33, 8'hCC, 8'h66, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_DITHER_ENABLE, 11'd0, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h12, 8'hED, 8'h80, 1'b1},
          1'b1, '{8'h12, 8'hED, 8'h80, 1'b0}},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h00, 8'hFF, 8'hFF, 1'b0},
          1'b1, '{8'h00, 8'hFF, 8'hFF, 1'b1}},
        '{ROW_REG, CFG_COLOR_BITS, 11'd1, '0, 1'b0, '0},
        '{ROW_REG, CFG_LINE_WIDTH, 11'd2047, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h7F, 8'h80, 8'hFF, 1'b1},
          1'b1, '{8'h00, 8'hFF, 8'hFF, 1'b0}},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'hFF, 8'h00, 8'h81, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_DITHER_ENABLE, 11'd1, '0, 1'b0, '0},
        '{ROW_REG, CFG_LINE_WIDTH, 11'd1024, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h7E, 8'h81, 8'h40, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_LINE_WIDTH, 11'd3, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'hA5, 8'h5A, 8'hFF, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h00, 8'hFF, 8'h00, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h3C, 8'hC3, 8'h99, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'hF0, 8'h0F, 8'h88, 1'b0}, 1'b0, '0},
        '{ROW_REG, CFG_COLOR_BITS, 11'd8, '0, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h6B, 8'h94, 8'hC7, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h2A, 8'hD5, 8'h10, 1'b0}, 1'b0, '0},
        '{ROW_PIX, CFG_COLOR_BITS, 11'd0, '{8'h80, 8'h7F, 8'h01, 1'b0}, 1'b0, '0}
    };

    // Clock, reset and every block input start at known values at time zero.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_pix_in               in_pix    = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_pix_out              out_pix;

    // Shared between the stimulus and the result side: steady turns idling off on both
    // sides, hold_req asks the result side for one long hold-off.
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    int mism_cnt    = 0;
    int line_ends   = 0;
    int pix_sent    = 0;
    int rand_phases = 0;

    // Results still owed by the block, oldest first.
    t_pix_out pending_px [$];

    // Mirror of the configuration registers as written.
    logic [3:0]  cfg_bits   = 4'd2;
    logic [10:0] cfg_width  = 11'd640;
    logic        cfg_dither = 1'b1;

    // Mirror of the diffusion state. Each entry holds blue, green and red, in that order.
    logic signed [ERR_W-1:0] row_err    [MAX_W][3];
    logic signed [ERR_W-1:0] run_err    [3];
    logic signed [ERR_W-1:0] diag_acc   [3];
    logic signed [ERR_W-1:0] corner_acc [3];
    int                      col_pos = 0;
    bit                      top_row = 1'b1;

    error_diffusion_dither u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_pix),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_pix)
    );

    always #6 clk = ~clk;

    // Floyd-Steinberg share of an error: (e * w) / 16, truncated toward zero.
    function automatic int fs_share(input int e, input int w);
        return (e * w) / 16;
    endfunction

    // Predicts the result of one pixel and advances the mirrored diffusion state.
    task automatic dither_pixel(input t_pix_in px, output t_pix_out res);
        int         width;
        int         bits;
        int         levels;
        int         col;
        int         v;
        int         q;
        int         e;
        bit         last;
        logic [7:0] chan_in  [3];
        logic [7:0] chan_out [3];
        width = (cfg_width < 2) ? 2 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
        bits = (cfg_bits < 1) ? 1 : ((cfg_bits > 8) ? 8 : int'(cfg_bits));
        levels = (1 << bits) - 1;
        chan_in[0] = px.in_blue;
        chan_in[1] = px.in_green;
        chan_in[2] = px.in_red;

        // A frame start wipes the running errors; the line store then reads as zero
        // until the first line of the frame is complete.
        if (px.frame_start) begin
            col_pos = 0;
            top_row = 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
                run_err[ch] = '0;
                diag_acc[ch] = '0;
                corner_acc[ch] = '0;
            end
        end

        // A column at or past the line end (width shrunk mid-line) closes the line.
        col = (col_pos >= width) ? width - 1 : col_pos;
        last = (col >= width - 1);

        for (int ch = 0; ch < 3; ch++) begin
            v = int'(chan_in[ch]);
            if (cfg_dither) begin
                // Row and right contributions are summed first and clamped once.
                v += top_row ? 0 : int'(row_err[col][ch]);
                v += int'(run_err[ch]);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
            end
            q = (((2 * v * levels + 255) / 510) * 255) / levels;
            e = cfg_dither ? v - q : 0;
            chan_out[ch] = q[7:0];

            if (col > 0) begin
                row_err[col - 1][ch] = ERR_W'(int'(diag_acc[ch]) + fs_share(e, 3));
            end
            diag_acc[ch] = ERR_W'(int'(corner_acc[ch]) + fs_share(e, 5));
            corner_acc[ch] = ERR_W'(fs_share(e, 1));
            run_err[ch] = ERR_W'(fs_share(e, 7));

            // Error that would fall beyond the right edge is dropped.
            if (last) begin
                row_err[col][ch] = diag_acc[ch];
                diag_acc[ch] = '0;
                corner_acc[ch] = '0;
                run_err[ch] = '0;
            end
        end

        res = '{chan_out[0], chan_out[1], chan_out[2], last};
        if (last) begin
            col_pos = 0;
            top_row = 1'b0;
        end else begin
            col_pos = col + 1;
        end
    endtask

    // Offers one pixel after an optional random gap and waits for it to be taken. Valid
    // stays high on return so that back-to-back items need no second assignment.
    task automatic send_pixel(input t_pix_in px, input bit known, input t_pix_out typed);
        t_pix_out pred;
        while (!steady && $urandom_range(0, 99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_pix <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        dither_pixel(px, pred);
        pending_px.push_back(known ? typed : pred);
        pix_sent++;
    endtask

    // Drops valid and waits until every owed result has come back, plus the block's
    // latency, so that a register write cannot land on a pixel still in flight.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // One register write; the mirror keeps only the bits the register holds.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COLOR_BITS:    cfg_bits = val[3:0];
            CFG_LINE_WIDTH:    cfg_width = val[10:0];
            CFG_DITHER_ENABLE: cfg_dither = val[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Channel values lean toward the rails and the quantizer midpoints.
    function automatic logic [7:0] pick_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'($urandom_range(126, 129));
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly short lines; now and then widths below two, medium lines, the store's full
    // depth, or widths beyond it.
    function automatic logic [10:0] pick_width();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 8)  return 11'($urandom_range(0, 1));
        if (r < 70) return 11'($urandom_range(2, 12));
        if (r < 88) return 11'($urandom_range(13, 64));
        if (r < 93) return 11'd1024;
        if (r < 96) return 11'($urandom_range(1025, 2047));
        return 11'($urandom_range(65, 1023));
    endfunction

    // Result side: random stall, one long hold-off on request, none while steady.
    initial begin : result_stall
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (steady) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < 23);
            end
        end
    end

    // Every result taken from the block is matched against the oldest owed result.
    always @(posedge clk) begin : check_results
        t_pix_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_px.size() == 0) begin
                $error("unexpected result %p with no pixel pending", out_pix);
                mism_cnt++;
            end else begin
                want = pending_px.pop_front();
                if (out_pix.out_blue !== want.out_blue) begin
                    $error("out_blue expected %0d got %0d", want.out_blue, out_pix.out_blue);
                    mism_cnt++;
                end
                if (out_pix.out_green !== want.out_green) begin
                    $error("out_green expected %0d got %0d", want.out_green,
                           out_pix.out_green);
                    mism_cnt++;
                end
                if (out_pix.out_red !== want.out_red) begin
                    $error("out_red expected %0d got %0d", want.out_red, out_pix.out_red);
                    mism_cnt++;
                end
                if (out_pix.line_end !== want.line_end) begin
                    $error("line_end expected %0d got %0d", want.line_end,
                           out_pix.line_end);
                    mism_cnt++;
                end
                if (out_pix.line_end === 1'b1) line_ends++;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run, including the store sweep after reset.
    initial begin
        #(64'd10_000_000);
        $display("error_diffusion_dither_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int       n_items;
        int       rand_items;
        int       dir_pix;
        t_pix_in  px;
        t_pix_out no_res;

        no_res = '0;
        rand_items = 0;
        for (int c = 0; c < MAX_W; c++) begin
            for (int ch = 0; ch < 3; ch++) row_err[c][ch] = '0;
        end
        for (int ch = 0; ch < 3; ch++) begin
            run_err[ch] = '0;
            diag_acc[ch] = '0;
            corner_acc[ch] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. The block sweeps its line store after reset and stalls input
        // meanwhile, which the handshake absorbs.
        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].kind == ROW_REG) begin
                settle();
                write_reg(DIR_ROWS[i].reg_idx, DIR_ROWS[i].reg_val);
            end else begin
                send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].known, DIR_ROWS[i].res);
            end
        end
        dir_pix = pix_sent;

        // Random phases. Each phase retunes some registers while idle, then streams a
        // run of pixels. Most phases open with a frame start so the line store is exercised;
        // the rest continue the old frame under new settings.
        while (rand_items < 800) begin
            settle();
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 4))
                    0:       write_reg(CFG_COLOR_BITS, {7'($urandom), 4'd0});
                    1:       write_reg(CFG_COLOR_BITS, {7'($urandom), 4'd15});
                    2:       write_reg(CFG_COLOR_BITS, 11'd1);
                    3:       write_reg(CFG_COLOR_BITS, 11'd8);
                    default: write_reg(CFG_COLOR_BITS, 11'($urandom_range(0, 15)));
                endcase
            end
            if ($urandom_range(0, 3) != 0) write_reg(CFG_LINE_WIDTH, pick_width());
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_DITHER_ENABLE,
                          {10'($urandom), 1'($urandom_range(0, 99) < 85)});
            end

            n_items = (cfg_width > 64) ? int'($urandom_range(20, 40))
                                       : int'($urandom_range(10, 70));
            steady = (rand_phases == 3);
            if (steady) n_items = 150;
            // Early on the result side holds off for a long stretch while pixels keep
            // coming, so the block fills up and stalls its input.
            if (rand_phases == 1) hold_req = 1'b1;

            for (int k = 0; k < n_items; k++) begin
                px.in_blue = pick_chan();
                px.in_green = pick_chan();
                px.in_red = pick_chan();
                if (k == 0) px.frame_start = ($urandom_range(0, 99) < 75);
                else        px.frame_start = ($urandom_range(0, 99) < 2);
                send_pixel(px, 1'b0, no_res);
                rand_items++;
            end
            steady = 1'b0;
            rand_phases++;
        end

        in_valid <= 1'b0;
        while (pending_px.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Ran %0d pixels (%0d from the directed table) over %0d random phases,",
                 pix_sent, dir_pix, rand_phases);
        $display("with %0d line ends and %0d field mismatches.", line_ends, mism_cnt);
        if (mism_cnt == 0) begin
            $display("error_diffusion_dither_tb: clean");
        end else begin
            $display("error_diffusion_dither_tb: errors");
        end
        $finish;
    end

endmodule
